### src/tiny_mlp_sigmoid_classifier_defines.svh
// assertion macros for the classifier pipeline
`ifndef TINY_MLP_SIGMOID_CLASSIFIER_DEFINES_SVH
`define TINY_MLP_SIGMOID_CLASSIFIER_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define TMSC_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pipeline check failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define TMSC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pipeline check failed");

`endif

### src/tmsc_pkg.sv
// shared types, register map and sigmoid table of the classifier
package tmsc_pkg;

  localparam int NUM_FEAT   = 7;
  localparam int NUM_STAGES = 5;
  localparam int ADDR_W     = 5;
  localparam int DATA_W     = 64;

  // register indexes, byte address is 8 * index
  localparam logic [1:0] REG_HIDDEN_A = 2'd0;
  localparam logic [1:0] REG_HIDDEN_B = 2'd1;
  localparam logic [1:0] REG_OUTPUT   = 2'd2;

  localparam logic [9:0] PRED_THRESHOLD = 10'd128;

  typedef logic [NUM_FEAT-1:0][7:0] feat_vec_t;

  typedef struct packed {
    logic [63:0] hidden_a;
    logic [63:0] hidden_b;
    logic [23:0] out_w;
  } weights_t;

  // per-stage load enables
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
    logic s5;
  } stage_en_t;

  localparam logic [7:0] SIG_TABLE [0:255] = '{
    8'd12,  8'd12,  8'd12,  8'd12,  8'd13,  8'd13,  8'd13,  8'd14,
    8'd14,  8'd14,  8'd15,  8'd15,  8'd15,  8'd16,  8'd16,  8'd16,
    8'd17,  8'd17,  8'd18,  8'd18,  8'd18,  8'd19,  8'd19,  8'd20,
    8'd20,  8'd21,  8'd21,  8'd21,  8'd22,  8'd22,  8'd23,  8'd23,
    8'd24,  8'd24,  8'd25,  8'd26,  8'd26,  8'd27,  8'd27,  8'd28,
    8'd28,  8'd29,  8'd30,  8'd30,  8'd31,  8'd32,  8'd32,  8'd33,
    8'd34,  8'd34,  8'd35,  8'd36,  8'd36,  8'd37,  8'd38,  8'd39,
    8'd39,  8'd40,  8'd41,  8'd42,  8'd43,  8'd44,  8'd44,  8'd45,
    8'd46,  8'd47,  8'd48,  8'd49,  8'd50,  8'd51,  8'd52,  8'd53,
    8'd54,  8'd55,  8'd56,  8'd57,  8'd58,  8'd59,  8'd60,  8'd61,
    8'd62,  8'd63,  8'd64,  8'd66,  8'd67,  8'd68,  8'd69,  8'd70,
    8'd72,  8'd73,  8'd74,  8'd75,  8'd76,  8'd78,  8'd79,  8'd80,
    8'd82,  8'd83,  8'd84,  8'd86,  8'd87,  8'd88,  8'd90,  8'd91,
    8'd92,  8'd94,  8'd95,  8'd97,  8'd98,  8'd99,  8'd101, 8'd102,
    8'd104, 8'd105, 8'd107, 8'd108, 8'd110, 8'd111, 8'd113, 8'd114,
    8'd116, 8'd117, 8'd119, 8'd120, 8'd122, 8'd123, 8'd125, 8'd126,
    8'd128, 8'd129, 8'd130, 8'd132, 8'd133, 8'd135, 8'd136, 8'd138,
    8'd139, 8'd141, 8'd142, 8'd144, 8'd145, 8'd147, 8'd148, 8'd150,
    8'd151, 8'd153, 8'd154, 8'd156, 8'd157, 8'd158, 8'd160, 8'd161,
    8'd163, 8'd164, 8'd165, 8'd167, 8'd168, 8'd169, 8'd171, 8'd172,
    8'd173, 8'd175, 8'd176, 8'd177, 8'd179, 8'd180, 8'd181, 8'd182,
    8'd183, 8'd185, 8'd186, 8'd187, 8'd188, 8'd189, 8'd191, 8'd192,
    8'd193, 8'd194, 8'd195, 8'd196, 8'd197, 8'd198, 8'd199, 8'd200,
    8'd201, 8'd202, 8'd203, 8'd204, 8'd205, 8'd206, 8'd207, 8'd208,
    8'd209, 8'd210, 8'd211, 8'd211, 8'd212, 8'd213, 8'd214, 8'd215,
    8'd216, 8'd216, 8'd217, 8'd218, 8'd219, 8'd219, 8'd220, 8'd221,
    8'd221, 8'd222, 8'd223, 8'd223, 8'd224, 8'd225, 8'd225, 8'd226,
    8'd227, 8'd227, 8'd228, 8'd228, 8'd229, 8'd229, 8'd230, 8'd231,
    8'd231, 8'd232, 8'd232, 8'd233, 8'd233, 8'd234, 8'd234, 8'd234,
    8'd235, 8'd235, 8'd236, 8'd236, 8'd237, 8'd237, 8'd237, 8'd238,
    8'd238, 8'd239, 8'd239, 8'd239, 8'd240, 8'd240, 8'd240, 8'd241,
    8'd241, 8'd241, 8'd242, 8'd242, 8'd242, 8'd243, 8'd243, 8'd243
  };

endpackage

### src/tiny_mlp_sigmoid_classifier.sv
// top level of the two-layer sigmoid classifier pipeline
//
//   channel  | direction | handshake           | payload
//   in_      | sink      | in_valid/in_ready   | seven feature bytes, sample_is_last
//   out_     | source    | out_valid/out_ready | prediction, result_is_last
//   apb      | slave     | psel/penable/pready | three weight registers, 64-bit data
//
// one sample enters per cycle while in_ready is high; each result passes through
// five register stages: products, sum, sigmoid lookup, output products, threshold
// rst_n clears the stage valid bits and the weight registers (all weights zero)
// each stage loads when empty or when the stage after it moves, so bubbles fill
// while out_ready is low and nothing is dropped or repeated
// in_ready falls only when all five stages hold a result
`include "tiny_mlp_sigmoid_classifier_defines.svh"

module tiny_mlp_sigmoid_classifier import tmsc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  // sample input
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_feature_one,
  input  logic [7:0]        in_feature_two,
  input  logic [7:0]        in_feature_three,
  input  logic [7:0]        in_feature_four,
  input  logic [7:0]        in_feature_five,
  input  logic [7:0]        in_feature_six,
  input  logic [7:0]        in_feature_seven,
  input  logic              in_sample_is_last,
  // prediction output
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_prediction,
  output logic              out_result_is_last,
  // register port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  weights_t               weights;
  feat_vec_t              feat;
  stage_en_t              en;
  logic [NUM_STAGES-1:0]  valid_r;
  logic [NUM_STAGES-1:0]  last_r;
  logic [NUM_STAGES-1:0]  rdy;
  logic [7:0]             sig_a;
  logic [7:0]             sig_b;
  logic                   pred;
  logic                   in_xfer;
  logic                   out_xfer;

  assign feat = {in_feature_seven, in_feature_six, in_feature_five, in_feature_four,
                 in_feature_three, in_feature_two, in_feature_one};

  // a stage may load when it is empty or its content moves on this cycle
  always_comb begin
    rdy[NUM_STAGES-1] = !valid_r[NUM_STAGES-1] || out_ready;
    for (int i = NUM_STAGES - 2; i >= 0; i--) begin
      rdy[i] = !valid_r[i] || rdy[i+1];
    end
  end

  assign en = '{s1: rdy[0], s2: rdy[1], s3: rdy[2], s4: rdy[3], s5: rdy[4]};

  assign in_ready = rdy[0];
  assign in_xfer  = in_valid && in_ready;
  assign out_xfer = out_valid && out_ready;

  // valid bits and last flag travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      if (rdy[0]) begin
        valid_r[0] <= in_valid;
      end
      for (int i = 1; i < NUM_STAGES; i++) begin
        if (rdy[i]) begin
          valid_r[i] <= valid_r[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      last_r[0] <= in_sample_is_last;
    end
    for (int i = 1; i < NUM_STAGES; i++) begin
      if (rdy[i]) begin
        last_r[i] <= last_r[i-1];
      end
    end
  end

  tmsc_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .weights (weights)
  );

  // stages 1 to 3, one unit per hidden neuron
  tmsc_hidden u_hidden_a (
    .clk     (clk),
    .en      (en),
    .feat    (feat),
    .weights (weights.hidden_a),
    .sig     (sig_a)
  );

  tmsc_hidden u_hidden_b (
    .clk     (clk),
    .en      (en),
    .feat    (feat),
    .weights (weights.hidden_b),
    .sig     (sig_b)
  );

  // stages 4 and 5
  tmsc_out u_out (
    .clk   (clk),
    .en    (en),
    .sig_a (sig_a),
    .sig_b (sig_b),
    .out_w (weights.out_w),
    .pred  (pred)
  );

  assign out_valid          = valid_r[NUM_STAGES-1];
  assign out_prediction     = pred;
  assign out_result_is_last = last_r[NUM_STAGES-1];

  // input only backs up when every stage is occupied
  `TMSC_ASSERT_IMPL(a_full_stall, !in_ready, &valid_r)
  // a draining output never blocks the input
  `TMSC_ASSERT_IMPL(a_drain_ready, out_ready, in_ready)
  // items in flight change only by transfers in and out
  `TMSC_ASSERT_NEXT(a_occupancy, 1'b1,
    $countones(valid_r) == $countones($past(valid_r)) + $past(in_xfer) - $past(out_xfer))

endmodule

### src/tmsc_regs.sv
// apb register file holding the neuron weights
module tmsc_regs import tmsc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output weights_t          weights
);

  weights_t   weights_r;
  logic [1:0] reg_idx;
  logic       wr_en;

  assign reg_idx = paddr[4:3];
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign weights = weights_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      weights_r <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_HIDDEN_A: weights_r.hidden_a <= pwdata;
        REG_HIDDEN_B: weights_r.hidden_b <= pwdata;
        REG_OUTPUT:   weights_r.out_w    <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_HIDDEN_A: prdata = weights_r.hidden_a;
      REG_HIDDEN_B: prdata = weights_r.hidden_b;
      REG_OUTPUT:   prdata = {40'd0, weights_r.out_w};
      default:      prdata = '0;
    endcase
  end

endmodule

### src/tmsc_hidden.sv
// hidden neuron: products, sum and sigmoid lookup over three stages
module tmsc_hidden import tmsc_pkg::*; (
  input  logic        clk,
  input  stage_en_t   en,
  input  feat_vec_t   feat,
  input  logic [63:0] weights,
  output logic [7:0]  sig
);

  logic [NUM_FEAT-1:0][15:0] prod_r;
  logic [7:0]                bias_r;
  logic [18:0]               sum;
  logic [7:0]                idx_r;
  logic [7:0]                sig_r;

  // stage 1: feature times weight, weight k sits in byte k+1, bias in byte 0
  always_ff @(posedge clk) begin
    if (en.s1) begin
      for (int k = 0; k < NUM_FEAT; k++) begin
        prod_r[k] <= feat[k] * weights[8*(k+1) +: 8];
      end
      bias_r <= weights[7:0];
    end
  end

  // stage 2: bias*256 plus products, keep bits 15:8 as table index
  always_comb begin
    sum = {3'd0, bias_r, 8'd0};
    for (int k = 0; k < NUM_FEAT; k++) begin
      sum = sum + {3'd0, prod_r[k]};
    end
  end

  always_ff @(posedge clk) begin
    if (en.s2) begin
      idx_r <= sum[15:8];
    end
  end

  // stage 3: sigmoid lookup
  always_ff @(posedge clk) begin
    if (en.s3) begin
      sig_r <= SIG_TABLE[idx_r];
    end
  end

  assign sig = sig_r;

endmodule

### src/tmsc_out.sv
// output neuron: weighted sigmoids and threshold over two stages
module tmsc_out import tmsc_pkg::*; (
  input  logic        clk,
  input  stage_en_t   en,
  input  logic [7:0]  sig_a,
  input  logic [7:0]  sig_b,
  input  logic [23:0] out_w,
  output logic        pred
);

  logic [15:0] prod_a_r;
  logic [15:0] prod_b_r;
  logic [7:0]  bias_r;
  logic [17:0] acc;
  logic        pred_r;

  always_ff @(posedge clk) begin
    if (en.s4) begin
      prod_a_r <= sig_a * out_w[15:8];
      prod_b_r <= sig_b * out_w[23:16];
      bias_r   <= out_w[7:0];
    end
  end

  assign acc = {2'd0, bias_r, 8'd0} + {2'd0, prod_a_r} + {2'd0, prod_b_r};

  always_ff @(posedge clk) begin
    if (en.s5) begin
      pred_r <= acc[17:8] > PRED_THRESHOLD;
    end
  end

  assign pred = pred_r;

endmodule

### test/tmsc_prediction_checker.sv
// checker that predicts each classifier decision and compares it with the output port
module tmsc_prediction_checker import tmsc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [7:0]        in_feature_one,
  input  logic [7:0]        in_feature_two,
  input  logic [7:0]        in_feature_three,
  input  logic [7:0]        in_feature_four,
  input  logic [7:0]        in_feature_five,
  input  logic [7:0]        in_feature_six,
  input  logic [7:0]        in_feature_seven,
  input  logic              in_sample_is_last,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic              out_prediction,
  input  logic              out_result_is_last,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  input  logic              pready,
  output int                failures,
  output int                pending
);

  typedef struct packed {
    logic prediction;
    logic is_last;
  } decision_t;

  logic [63:0] hidden_a_w;
  logic [63:0] hidden_b_w;
  logic [23:0] output_w;
  decision_t   expected_decisions [$];
  decision_t   oldest;
  int          mismatch_count = 0;
  feat_vec_t   sample;

  initial begin
    failures = 0;
    pending  = 0;
  end

  assign sample = {in_feature_seven, in_feature_six, in_feature_five, in_feature_four,
                   in_feature_three, in_feature_two, in_feature_one};

  // hidden neuron: bias * 256 plus products, index wraps to the low byte of sum >> 8
  function automatic logic [7:0] hidden_activation(input logic [63:0] w, input feat_vec_t f);
    logic [31:0] acc;
    acc = {16'd0, w[7:0], 8'd0};
    for (int k = 1; k <= NUM_FEAT; k++) begin
      acc += 32'(f[k-1]) * 32'(w[8*k +: 8]);
    end
    return SIG_TABLE[acc[15:8]];
  endfunction

  function automatic logic class_decision(input logic [63:0] wa, input logic [63:0] wb,
                                          input logic [23:0] wo, input feat_vec_t f);
    logic [31:0] acc;
    acc = {16'd0, wo[7:0], 8'd0}
        + 32'(hidden_activation(wa, f)) * 32'(wo[15:8])
        + 32'(hidden_activation(wb, f)) * 32'(wo[23:16]);
    return acc[31:8] > 24'(PRED_THRESHOLD);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      hidden_a_w = '0;
      hidden_b_w = '0;
      output_w   = '0;
      expected_decisions.delete();
    end else begin
      // register writes, slot 3 is unmapped
      if (psel && penable && pwrite && pready) begin
        case (paddr[ADDR_W-1:3])
          REG_HIDDEN_A: hidden_a_w = pwdata[63:0];
          REG_HIDDEN_B: hidden_b_w = pwdata[63:0];
          REG_OUTPUT:   output_w   = pwdata[23:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        expected_decisions.push_back(
          '{class_decision(hidden_a_w, hidden_b_w, output_w, sample), in_sample_is_last});
      end
      if (out_valid && out_ready) begin
        if (expected_decisions.size() == 0) begin
          $error("result with nothing expected: prediction %0d, result_is_last %0d",
                 out_prediction, out_result_is_last);
          mismatch_count++;
        end else begin
          oldest = expected_decisions.pop_front();
          if (out_prediction !== oldest.prediction) begin
            $error("prediction: expected %0d, got %0d", oldest.prediction, out_prediction);
            mismatch_count++;
          end
          if (out_result_is_last !== oldest.is_last) begin
            $error("result_is_last: expected %0d, got %0d", oldest.is_last,
                   out_result_is_last);
            mismatch_count++;
          end
        end
      end
    end
    failures <= mismatch_count;
    pending  <= expected_decisions.size();
  end

endmodule

### test/tb_tiny_mlp_sigmoid_classifier.sv
// testbench top: clock, reset, sample and weight stimulus, and the final verdict
module tb_tiny_mlp_sigmoid_classifier;
  import tmsc_pkg::*;

  // slot 3 of the register map holds nothing, writes there must be dropped
  localparam logic [1:0] REG_UNMAPPED = 2'd3;
  localparam int HOLD_OFF_CYCLES = 80;
  localparam int TAIL_CYCLES     = 2 * NUM_STAGES;
  localparam int RANDOM_PHASES   = 8;
  localparam int PHASE_ITEMS     = 112;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [7:0]        in_feature_one = '0;
  logic [7:0]        in_feature_two = '0;
  logic [7:0]        in_feature_three = '0;
  logic [7:0]        in_feature_four = '0;
  logic [7:0]        in_feature_five = '0;
  logic [7:0]        in_feature_six = '0;
  logic [7:0]        in_feature_seven = '0;
  logic              in_sample_is_last = 1'b0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic              out_prediction;
  logic              out_result_is_last;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  int                failures;
  int                pending;

  // traffic shaping knobs shared by the sample source and the result sink
  bit tx_eager = 1'b0;      // sender offers back to back
  bit rx_eager = 1'b0;      // receiver never stalls
  bit hold_request = 1'b0;  // receiver holds off for a long stretch once

  tiny_mlp_sigmoid_classifier uut (.*);

  tmsc_prediction_checker checker_i (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // generous ceiling, the slowest legal run stays far below it
  initial begin
    #2_000_000;
    $display("[tiny_mlp_sigmoid_classifier] ERROR");
    $finish;
  end

  // register write: setup cycle, then access cycle until pready, then back to idle
  task automatic write_register(input logic [1:0] index, input logic [DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {index, 3'b000};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // one sample transfer; valid stays up across back to back items
  task automatic offer_sample(input feat_vec_t f, input logic last);
    int unsigned gap;
    gap = tx_eager ? 0 : $urandom_range(0, 5);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_feature_one    <= f[0];
    in_feature_two    <= f[1];
    in_feature_three  <= f[2];
    in_feature_four   <= f[3];
    in_feature_five   <= f[4];
    in_feature_six    <= f[5];
    in_feature_seven  <= f[6];
    in_sample_is_last <= last;
    do @(posedge clk); while (!in_ready);
  endtask

  // stop offering and wait until every decision has left the pipeline;
  // pending is registered, so look in the cycle after the last input transfer
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // mostly random bytes, with the two extremes showing up often
  function automatic feat_vec_t random_features();
    feat_vec_t f;
    for (int k = 0; k < NUM_FEAT; k++) begin
      case ($urandom_range(0, 9))
        0:       f[k] = 8'h00;
        1:       f[k] = 8'hFF;
        default: f[k] = 8'($urandom_range(0, 255));
      endcase
    end
    return f;
  endfunction

  // weight sets for the random phases
  task automatic load_weights(input int style);
    logic [63:0] wa;
    logic [63:0] wb;
    logic [63:0] wo;
    wa = {$urandom, $urandom};
    wb = {$urandom, $urandom};
    wo = {$urandom, $urandom};  // bits above 23 are junk the block must drop
    case (style)
      1: begin
        // light weights keep hidden sums mostly inside the table
        wa &= {8{8'h1F}};
        wb &= {8{8'h1F}};
      end
      2: begin
        // saturated hidden weights, sums wrap hard
        wa = '1;
        wb = '1;
      end
      3: wo[7:0] = 8'($urandom_range(0, 63));  // low output bias splits decisions
      4: begin
        wa = '0;
        wb = '0;
        wo[23:0] = '0;
      end
      default: ;
    endcase
    write_register(REG_HIDDEN_A, wa);
    write_register(REG_HIDDEN_B, wb);
    write_register(REG_OUTPUT, wo);
    if ($urandom_range(0, 1) != 0) begin
      write_register(REG_UNMAPPED, {$urandom, $urandom});
    end
  endtask

  // result sink: random stalls, eager stretches and one long hold-off
  initial begin : result_sink
    int unsigned stall;
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end else begin
        stall = rx_eager ? 0 : $urandom_range(0, 5);
        if (stall != 0) begin
          out_ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // sample source and verdict
  initial begin : sample_source
    feat_vec_t f;
    int        style;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset weights are all zero, every decision comes out 0
    offer_sample('0, 1'b0);
    offer_sample('1, 1'b1);
    offer_sample(random_features(), 1'b0);
    drain_results();

    // hand-picked weights; output write carries junk above bit 23,
    // and a write to the unmapped slot must change nothing
    write_register(REG_HIDDEN_A, 64'h7060_5040_3020_10F0);
    write_register(REG_HIDDEN_B, 64'h0102_0408_1020_4080);
    write_register(REG_OUTPUT, 64'hDEAD_BEEF_00C0_8020);
    write_register(REG_UNMAPPED, '1);
    offer_sample('0, 1'b0);
    offer_sample('1, 1'b1);
    // one feature at full scale at a time
    for (int k = 0; k < NUM_FEAT; k++) begin
      f = '0;
      f[k] = 8'hFF;
      offer_sample(f, k[0]);
    end
    offer_sample({NUM_FEAT{8'h55}}, 1'b0);
    offer_sample({NUM_FEAT{8'hAA}}, 1'b1);
    drain_results();

    // all weights saturated: hidden sum >> 8 runs past 255 and wraps
    write_register(REG_HIDDEN_A, '1);
    write_register(REG_HIDDEN_B, '1);
    write_register(REG_OUTPUT, '1);
    offer_sample('0, 1'b0);
    offer_sample('1, 1'b1);
    offer_sample({NUM_FEAT{8'h80}}, 1'b0);
    drain_results();

    // threshold edge: with output weights zeroed out, output value is the bias
    write_register(REG_OUTPUT, 64'd128);  // exactly 128, not above, decision 0
    offer_sample(random_features(), 1'b1);
    drain_results();
    write_register(REG_OUTPUT, 64'd129);  // one above, decision 1
    offer_sample(random_features(), 1'b0);
    drain_results();

    // random phases, new weights each time, written only with the pipeline empty
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      style = (p == RANDOM_PHASES - 1) ? 4 : p % 4;
      load_weights(style);
      tx_eager = (p % 3 == 1);
      rx_eager = (p % 4 == 2);
      // back to back samples against a long receiver hold-off fill the pipeline
      if (p == 1) hold_request = 1'b1;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // sender waits out every decision halfway through one phase
        if (p == 3 && i == PHASE_ITEMS / 2) drain_results();
        offer_sample(random_features(), $urandom_range(0, 7) == 0);
      end
      drain_results();
    end

    tx_eager = 1'b0;
    repeat (TAIL_CYCLES) @(posedge clk);
    if (failures == 0 && pending == 0) begin
      $display("[tiny_mlp_sigmoid_classifier] OK");
    end else begin
      $display("[tiny_mlp_sigmoid_classifier] ERROR");
    end
    $finish;
  end

endmodule

### files.f
+incdir+src
src/tmsc_pkg.sv
src/tmsc_regs.sv
src/tmsc_hidden.sv
src/tmsc_out.sv
src/tiny_mlp_sigmoid_classifier.sv
test/tmsc_prediction_checker.sv
test/tb_tiny_mlp_sigmoid_classifier.sv
